@@ hdl/actuator_command_supervisor_defines.svh @@
// Assertion macros for the actuator command supervisor.
// Assumes the asserting module has clk and arst_n in scope.
`ifndef ACTUATOR_COMMAND_SUPERVISOR_DEFINES_SVH
`define ACTUATOR_COMMAND_SUPERVISOR_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define ACS_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("acs assertion failed");
`define ACS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("acs assertion failed");
`else
`define ACS_ASSERT_IMPL(label, ante, cons)
`define ACS_ASSERT_NEXT(label, ante, cons)
`endif

`endif

@@ hdl/acs_pkg.sv @@
// Shared types and constants of the actuator command supervisor.
// No dependencies.
package acs_pkg;

	localparam logic [1:0] ACT_HOLD  = 2'd0;
	localparam logic [1:0] ACT_APPLY = 2'd1;
	localparam logic [1:0] ACT_STOP  = 2'd2;

	localparam int unsigned FB_DRIVER  = 0;
	localparam int unsigned FB_IPC     = 1;
	localparam int unsigned FB_TIMEOUT = 2;
	localparam int unsigned FB_LIMITED = 3;
	localparam int unsigned FB_ESTOP   = 4;
	localparam int unsigned FB_WIDTH   = 5;

	localparam logic [1:0] REG_RPM_LIMIT     = 2'd0;
	localparam logic [1:0] REG_STEER_MIN     = 2'd1;
	localparam logic [1:0] REG_STEER_MAX     = 2'd2;
	localparam logic [1:0] REG_TIMEOUT_TICKS = 2'd3;

	localparam logic        [14:0] RPM_LIMIT_RST     = 15'd200;
	localparam logic signed [15:0] STEER_MIN_RST     = -16'sd30;
	localparam logic signed [15:0] STEER_MAX_RST     = 16'sd30;
	localparam logic        [31:0] TIMEOUT_TICKS_RST = 32'd500;

	typedef struct packed {
		logic signed [15:0] left_rpm;
		logic signed [15:0] right_rpm;
		logic signed [15:0] servo_0;
		logic signed [15:0] servo_1;
		logic               hit;
	} targets_t;

endpackage

@@ hdl/actuator_command_supervisor.sv @@
// Top level of the actuator command supervisor: tick register, supervision logic,
// result register, configuration registers. Depends on acs_pkg, acs_clamp and
// actuator_command_supervisor_defines.svh.
//
// channel | handshake            | payload
// in      | in_valid / in_ready  | command_valid .. stop_error, one tick
// out     | out_valid / out_ready| command_accepted .. fault_flags
// cfg     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// An accepted tick sits in the tick register, then goes through the clamps and the
// state update into the result register, one tick per cycle when not stalled.
// arst_n clears the state, the pipeline valids and loads the register defaults.
// A stalled result holds the tick register; in_ready drops only when both are full.
// cfg_ready is always high.
`include "actuator_command_supervisor_defines.svh"

module actuator_command_supervisor (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               command_valid,
	input  logic signed [15:0] left_rpm_in,
	input  logic signed [15:0] right_rpm_in,
	input  logic signed [15:0] servo_in_0,
	input  logic signed [15:0] servo_in_1,
	input  logic               estop_request,
	input  logic               drive_enable,
	input  logic               rx_fault,
	input  logic               housekeeping_error,
	input  logic               apply_error,
	input  logic               stop_error,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               command_accepted,
	output logic        [1:0]  action,
	output logic signed [15:0] left_rpm_out,
	output logic signed [15:0] right_rpm_out,
	output logic signed [15:0] servo_out_0,
	output logic signed [15:0] servo_out_1,
	output logic        [4:0]  fault_flags,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic        [1:0]  cfg_index,
	input  logic        [31:0] cfg_data
);

	logic        [14:0] rpm_limit_q;
	logic signed [15:0] steer_min_q;
	logic signed [15:0] steer_max_q;
	logic        [31:0] timeout_q;

	logic               valid_s1;
	logic               cmd_s1;
	logic signed [15:0] left_s1, right_s1, servo0_s1, servo1_s1;
	logic               estop_s1, enable_s1, rx_s1, hk_s1, ap_s1, st_s1;

	logic        [31:0] elapsed_q;
	logic               estop_latched_q;
	logic        [4:0]  fault_q;

	logic               out_valid_q;
	logic               accepted_q;
	logic        [1:0]  action_q;
	logic signed [15:0] left_q, right_q, servo0_q, servo1_q;

	logic               advance;
	acs_pkg::targets_t  tgt;

	logic        [31:0] elapsed_d;
	logic               estop_d;
	logic        [4:0]  fault_d;
	logic               accepted_d;
	logic        [1:0]  action_d;

	logic               out_apply;
	logic               out_stop;
	logic               targets_zero;

	assign advance   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || !out_valid_q || out_ready;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rpm_limit_q <= acs_pkg::RPM_LIMIT_RST;
			steer_min_q <= acs_pkg::STEER_MIN_RST;
			steer_max_q <= acs_pkg::STEER_MAX_RST;
			timeout_q   <= acs_pkg::TIMEOUT_TICKS_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				acs_pkg::REG_RPM_LIMIT:     rpm_limit_q <= cfg_data[14:0];
				acs_pkg::REG_STEER_MIN:     steer_min_q <= signed'(cfg_data[15:0]);
				acs_pkg::REG_STEER_MAX:     steer_max_q <= signed'(cfg_data[15:0]);
				acs_pkg::REG_TIMEOUT_TICKS: timeout_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			cmd_s1    <= command_valid;
			left_s1   <= left_rpm_in;
			right_s1  <= right_rpm_in;
			servo0_s1 <= servo_in_0;
			servo1_s1 <= servo_in_1;
			estop_s1  <= estop_request;
			enable_s1 <= drive_enable;
			rx_s1     <= rx_fault;
			hk_s1     <= housekeeping_error;
			ap_s1     <= apply_error;
			st_s1     <= stop_error;
		end
	end

	acs_clamp u_clamp (
		.rpm_limit (rpm_limit_q),
		.steer_min (steer_min_q),
		.steer_max (steer_max_q),
		.left_rpm  (left_s1),
		.right_rpm (right_s1),
		.servo_0   (servo0_s1),
		.servo_1   (servo1_s1),
		.tgt       (tgt)
	);

	always_comb begin
		fault_d    = fault_q;
		elapsed_d  = elapsed_q;
		estop_d    = estop_latched_q;
		accepted_d = 1'b0;
		action_d   = acs_pkg::ACT_HOLD;
		if (hk_s1) begin
			fault_d[acs_pkg::FB_DRIVER] = 1'b1;
			action_d = acs_pkg::ACT_STOP;
		end else begin
			if (rx_s1) begin
				fault_d[acs_pkg::FB_IPC] = 1'b1;
			end
			if (cmd_s1) begin
				accepted_d = 1'b1;
				fault_d[acs_pkg::FB_TIMEOUT] = 1'b0;
				fault_d[acs_pkg::FB_LIMITED] = tgt.hit;
				elapsed_d = '0;
				if (estop_s1) begin
					estop_d = 1'b1;
					fault_d[acs_pkg::FB_ESTOP] = 1'b1;
					action_d = acs_pkg::ACT_STOP;
				end else if (estop_latched_q) begin
					action_d = acs_pkg::ACT_STOP;
					if (!enable_s1) begin
						estop_d = 1'b0;
						fault_d[acs_pkg::FB_ESTOP] = 1'b0;
					end
				end else if (!enable_s1) begin
					action_d = acs_pkg::ACT_STOP;
				end else if (ap_s1) begin
					fault_d[acs_pkg::FB_DRIVER] = 1'b1;
					action_d = acs_pkg::ACT_STOP;
				end else begin
					action_d = acs_pkg::ACT_APPLY;
				end
			end else if (elapsed_q != '1) begin
				elapsed_d = elapsed_q + 32'd1;
			end
			if (elapsed_d >= timeout_q && !fault_d[acs_pkg::FB_TIMEOUT]) begin
				fault_d[acs_pkg::FB_TIMEOUT] = 1'b1;
				action_d = acs_pkg::ACT_STOP;
			end
		end
		if (action_d == acs_pkg::ACT_STOP && st_s1) begin
			fault_d[acs_pkg::FB_DRIVER] = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elapsed_q       <= '0;
			estop_latched_q <= 1'b0;
			fault_q         <= '0;
			out_valid_q     <= 1'b0;
		end else begin
			if (advance) begin
				elapsed_q       <= elapsed_d;
				estop_latched_q <= estop_d;
				fault_q         <= fault_d;
				out_valid_q     <= 1'b1;
			end else if (out_ready) begin
				out_valid_q     <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			accepted_q <= accepted_d;
			action_q   <= action_d;
			if (action_d == acs_pkg::ACT_APPLY) begin
				left_q   <= tgt.left_rpm;
				right_q  <= tgt.right_rpm;
				servo0_q <= tgt.servo_0;
				servo1_q <= tgt.servo_1;
			end else begin
				left_q   <= '0;
				right_q  <= '0;
				servo0_q <= '0;
				servo1_q <= '0;
			end
		end
	end

	assign out_valid        = out_valid_q;
	assign command_accepted = accepted_q;
	assign action           = action_q;
	assign left_rpm_out     = left_q;
	assign right_rpm_out    = right_q;
	assign servo_out_0      = servo0_q;
	assign servo_out_1      = servo1_q;
	assign fault_flags      = fault_q;

	assign out_apply    = out_valid_q && action_q == acs_pkg::ACT_APPLY;
	assign out_stop     = out_valid_q && action_q == acs_pkg::ACT_STOP;
	assign targets_zero = left_q == '0 && right_q == '0 && servo0_q == '0 && servo1_q == '0;

	`ACS_ASSERT_IMPL(a_targets_zero_unless_apply, out_valid_q && !out_apply, targets_zero)
	`ACS_ASSERT_IMPL(a_apply_needs_command, out_apply, accepted_q && !fault_q[acs_pkg::FB_ESTOP])
	`ACS_ASSERT_IMPL(a_estop_flag_tracks_latch, 1'b1, estop_latched_q == fault_q[acs_pkg::FB_ESTOP])
	`ACS_ASSERT_IMPL(a_timeout_issues_stop, $rose(fault_q[acs_pkg::FB_TIMEOUT]), out_stop)

endmodule

@@ hdl/acs_clamp.sv @@
// Clamps the wheel and steering targets of one command to the configured limits.
// Depends on acs_pkg.
module acs_clamp (
	input  logic        [14:0] rpm_limit,
	input  logic signed [15:0] steer_min,
	input  logic signed [15:0] steer_max,
	input  logic signed [15:0] left_rpm,
	input  logic signed [15:0] right_rpm,
	input  logic signed [15:0] servo_0,
	input  logic signed [15:0] servo_1,
	output acs_pkg::targets_t  tgt
);

	function automatic logic [16:0] bound(input logic signed [16:0] v,
		input logic signed [16:0] lo, input logic signed [16:0] hi);
		logic [16:0] r;
		if (v < lo) begin
			r = {1'b1, lo[15:0]};
		end else if (v > hi) begin
			r = {1'b1, hi[15:0]};
		end else begin
			r = {1'b0, v[15:0]};
		end
		return r;
	endfunction

	logic signed [16:0] lim_pos;
	logic signed [16:0] lim_neg;
	logic signed [16:0] smin_ext;
	logic signed [16:0] smax_ext;
	logic [16:0] r_left, r_right, r_s0, r_s1;

	assign lim_pos  = signed'({2'b00, rpm_limit});
	assign lim_neg  = -lim_pos;
	assign smin_ext = 17'(steer_min);
	assign smax_ext = 17'(steer_max);

	assign r_left  = bound(17'(left_rpm), lim_neg, lim_pos);
	assign r_right = bound(17'(right_rpm), lim_neg, lim_pos);
	assign r_s0    = bound(17'(servo_0), smin_ext, smax_ext);
	assign r_s1    = bound(17'(servo_1), smin_ext, smax_ext);

	assign tgt.left_rpm  = signed'(r_left[15:0]);
	assign tgt.right_rpm = signed'(r_right[15:0]);
	assign tgt.servo_0   = signed'(r_s0[15:0]);
	assign tgt.servo_1   = signed'(r_s1[15:0]);
	assign tgt.hit       = r_left[16] | r_right[16] | r_s0[16] | r_s1[16];

endmodule
